// ===== sv/lws_pkg.sv =====
// ----------------------------------------------------------------------------
// lws_pkg: shared types and constants
// Operation codes, register indexes, histogram bounds and percentile ranks
// used by the latency window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package lws_pkg;

  // Default upper bound of the sample window.
  localparam int WindowMaxDefault = 1024;
  // Window size after reset, clamped to the window bound.
  localparam int WindowResetDefault = 1024;

  localparam int NumBuckets = 11;
  localparam int NumPct = 4;

  // Operation codes of an input beat.
  localparam logic [1:0] OpRecord = 2'd0;
  localparam logic [1:0] OpStats  = 2'd1;
  localparam logic [1:0] OpHist   = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegProfEnable = 2'd0;
  localparam logic [1:0] RegWindowSize = 2'd1;

  // Result kinds.
  localparam logic KindStats = 1'b0;
  localparam logic KindHist  = 1'b1;

  // Percentile ranks in hundredths: p5, p50, p95, p99.
  localparam logic [6:0] PctHund [NumPct] = '{7'd5, 7'd50, 7'd95, 7'd99};

  // Upper bound of each bounded histogram bucket in microseconds.
  function automatic logic [31:0] bucket_bound(input logic [3:0] idx);
    logic [31:0] b;
    case (idx)
      4'd0:    b = 32'd0;
      4'd1:    b = 32'd1;
      4'd2:    b = 32'd5;
      4'd3:    b = 32'd10;
      4'd4:    b = 32'd25;
      4'd5:    b = 32'd50;
      4'd6:    b = 32'd100;
      4'd7:    b = 32'd250;
      4'd8:    b = 32'd500;
      4'd9:    b = 32'd1000;
      default: b = 32'hFFFF_FFFF;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/latency_window_statistics_top.sv =====
// ----------------------------------------------------------------------------
// latency_window_statistics_top: latency statistics over a sample window
// Keeps count, sum, min and max of latency samples and a ring of recent
// samples in RAM; answers stats queries with mean and percentiles and
// histogram queries with eleven cumulative bucket beats.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Handshake
//  command   start_i, operation_i, latency_us_i       start_i && !busy_o
//  config    cfg_valid_i, cfg_index_i, cfg_data_i     cfg_valid_i && cfg_ready_o
//  result    result_valid_o and result fields         strobe, one cycle
//
//  Record and clear leave busy_o low.
//  A stats query holds busy_o. With no samples it goes straight to its result;
//  otherwise it runs the 64-step divider, then ranks each sample of a window
//  of N samples against the whole window through the RAM read port, taking a
//  read, a wait, a scan of the window and a check, and then drives the result.
//  A histogram query scans the window and then gives 11 result beats.
//  A configuration write is taken only while idle and no command is offered.
//  Reset clears all statistics; the sample RAM needs no clearing pass.
//  The receiver cannot stall; each result beat stands for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_window_statistics_top import lws_pkg::*; #(
  parameter int WINDOW_MAX = WindowMaxDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] latency_us_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  output logic             result_valid_o,
  output logic             result_kind_o,
  output logic [63:0]      sample_total_o,
  output logic [31:0]      mean_latency_o,
  output logic [31:0]      least_latency_o,
  output logic [31:0]      greatest_latency_o,
  output logic [31:0]      pct5_o,
  output logic [31:0]      pct50_o,
  output logic [31:0]      pct95_o,
  output logic [31:0]      pct99_o,
  output logic [3:0]       bucket_index_o,
  output logic [10:0]      bucket_tally_o,
  output logic             last_o
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int PW = FW + 7;
  localparam int ResetWin = (WindowResetDefault > WINDOW_MAX) ? WINDOW_MAX
                                                              : WindowResetDefault;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StCand  = 4'd2;
  localparam logic [3:0] StCWait = 4'd3;
  localparam logic [3:0] StScan  = 4'd4;
  localparam logic [3:0] StCheck = 4'd5;
  localparam logic [3:0] StSOut  = 4'd6;
  localparam logic [3:0] StHScan = 4'd7;
  localparam logic [3:0] StHOut  = 4'd8;

  // Advance a ring position with wrap at the window size.
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a,
                                             input logic [FW-1:0] w);
    logic [FW:0] s;
    s = (FW+1)'(a) + (FW+1)'(1);
    return (s == (FW+1)'(w)) ? '0 : AW'(s);
  endfunction

  logic [3:0]    state_q;
  logic          prof_q;
  logic [FW-1:0] win_q, fill_q;
  logic [AW-1:0] head_q;
  logic [63:0]   count_q, sum_q;
  logic [31:0]   min_q, max_q, mean_q;

  logic [FW-1:0] issue_cnt_q, cand_cnt_q, lt_q, le_q;
  logic [AW-1:0] scan_addr_q, cand_addr_q;
  logic          rd_vld_q;
  logic [31:0]   cand_q;
  logic [PW-1:0] np_q [NumPct];
  logic [31:0]   pct_q [NumPct];
  logic [FW-1:0] hist_q [NumBuckets];
  logic [3:0]    hb_q;

  logic          cmd_acc, cfg_acc, rec_en, div_start, div_done;
  logic [63:0]   quotient;
  logic [64:0]   sum_add;
  logic [FW:0]   st_sum;
  logic [AW-1:0] win_start;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [31:0]   wcfg;
  logic [PW-1:0] lt100, le100;

  assign busy_o      = state_q != StIdle;
  assign cfg_ready_o = !busy_o && !start_i;
  assign cmd_acc     = start_i && !busy_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign rec_en      = cmd_acc && operation_i == OpRecord && prof_q;
  assign div_start   = cmd_acc && operation_i == OpStats && count_q != '0;
  assign sum_add     = {1'b0, sum_q} + 65'(latency_us_i);

  // Oldest sample's ring position.
  always_comb begin
    st_sum    = (FW+1)'(head_q) + (FW+1)'(win_q) - (FW+1)'(fill_q);
    if (st_sum >= (FW+1)'(win_q)) begin
      st_sum = st_sum - (FW+1)'(win_q);
    end
    win_start = AW'(st_sum);
  end

  // Clamp a written window size into range.
  always_comb begin
    wcfg = 32'(cfg_data_i);
    if (wcfg == 32'd0) begin
      wcfg = 32'd1;
    end
    if (wcfg > 32'(WINDOW_MAX)) begin
      wcfg = 32'(WINDOW_MAX);
    end
  end

  assign rd_addr = (state_q == StCand) ? cand_addr_q : scan_addr_q;
  assign lt100   = PW'(lt_q) * PW'(100);
  assign le100   = PW'(le_q) * PW'(100);

  lws_ram #(.Width(32), .Depth(WINDOW_MAX)) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (rec_en),
    .wr_addr_i(head_q),
    .wr_data_i(latency_us_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  lws_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Statistics registers, configuration and the query sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      prof_q         <= 1'b1;
      win_q          <= FW'(ResetWin);
      fill_q         <= '0;
      head_q         <= '0;
      count_q        <= '0;
      sum_q          <= '0;
      min_q          <= '1;
      max_q          <= '0;
      rd_vld_q       <= 1'b0;
      result_valid_o <= 1'b0;
      scan_addr_q    <= '0;
      cand_addr_q    <= '0;
      issue_cnt_q    <= '0;
      cand_cnt_q     <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_acc && cfg_index_i == RegProfEnable) begin
        prof_q <= cfg_data_i[0];
      end else if (cfg_acc && cfg_index_i == RegWindowSize) begin
        win_q  <= FW'(wcfg);
        head_q <= '0;
        fill_q <= '0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_acc) begin
            case (operation_i)
              OpRecord: begin
                if (count_q < 64'hFFFF_FFFF_FFFF_FFFE) begin
                  count_q <= count_q + 64'd1;
                end
                sum_q <= sum_add[64] ? '1 : sum_add[63:0];
                if (latency_us_i < min_q) min_q <= latency_us_i;
                if (latency_us_i > max_q) max_q <= latency_us_i;
                if (prof_q) begin
                  head_q <= wrap_inc(head_q, win_q);
                  if (fill_q < win_q) fill_q <= fill_q + FW'(1);
                end
              end
              OpStats: begin
                state_q <= (count_q != '0) ? StDiv : StSOut;
              end
              OpHist: begin
                state_q     <= (prof_q && fill_q != '0) ? StHScan : StHOut;
                scan_addr_q <= win_start;
                issue_cnt_q <= '0;
              end
              OpClear: begin
                count_q <= '0;
                sum_q   <= '0;
                min_q   <= '1;
                max_q   <= '0;
                head_q  <= '0;
                fill_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q     <= (prof_q && fill_q != '0) ? StCand : StSOut;
            cand_addr_q <= win_start;
            cand_cnt_q  <= '0;
          end
        end
        StCand: state_q <= StCWait;
        StCWait: begin
          state_q     <= StScan;
          scan_addr_q <= win_start;
          issue_cnt_q <= '0;
        end
        StScan, StHScan: begin
          // Issue one read a cycle; the data comes from the registered RAM read.
          rd_vld_q <= issue_cnt_q != fill_q;
          if (issue_cnt_q != fill_q) begin
            issue_cnt_q <= issue_cnt_q + FW'(1);
            scan_addr_q <= wrap_inc(scan_addr_q, win_q);
          end else if (!rd_vld_q) begin
            state_q <= (state_q == StScan) ? StCheck : StHOut;
          end
        end
        StCheck: begin
          cand_cnt_q  <= cand_cnt_q + FW'(1);
          cand_addr_q <= wrap_inc(cand_addr_q, win_q);
          state_q     <= (cand_cnt_q + FW'(1) == fill_q) ? StSOut : StCand;
        end
        StSOut: begin
          result_valid_o <= 1'b1;
          state_q        <= StIdle;
        end
        StHOut: begin
          result_valid_o <= 1'b1;
          if (hb_q == 4'(NumBuckets - 1)) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Query datapath: ranks, percentiles, tallies and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      mean_q <= '0;
      hb_q   <= '0;
      lt_q   <= '0;
      le_q   <= '0;
      for (int t = 0; t < NumPct; t++) begin
        pct_q[t] <= '0;
        np_q[t]  <= PW'(fill_q) * PW'(PctHund[t]);
      end
      for (int b = 0; b < NumBuckets; b++) begin
        hist_q[b] <= '0;
      end
    end
    if (div_done) begin
      mean_q <= (quotient[63:32] != '0) ? '1 : quotient[31:0];
    end
    if (state_q == StCWait) begin
      cand_q <= rd_data;
      lt_q   <= '0;
      le_q   <= '0;
    end
    if (rd_vld_q && state_q == StScan) begin
      if (rd_data < cand_q)  lt_q <= lt_q + FW'(1);
      if (rd_data <= cand_q) le_q <= le_q + FW'(1);
    end
    if (rd_vld_q && state_q == StHScan) begin
      for (int b = 0; b < NumBuckets - 1; b++) begin
        if (rd_data <= bucket_bound(4'(b))) hist_q[b] <= hist_q[b] + FW'(1);
      end
      hist_q[NumBuckets-1] <= hist_q[NumBuckets-1] + FW'(1);
    end
    // The candidate sits at sorted index idx when lt <= idx < le,
    // with idx + 1 = ceil(N * p / 100).
    if (state_q == StCheck) begin
      for (int t = 0; t < NumPct; t++) begin
        if (lt100 < np_q[t] && np_q[t] <= le100) pct_q[t] <= cand_q;
      end
    end
    if (state_q == StSOut) begin
      result_kind_o      <= KindStats;
      sample_total_o     <= count_q;
      mean_latency_o     <= mean_q;
      least_latency_o    <= (count_q == '0) ? '0 : min_q;
      greatest_latency_o <= max_q;
      pct5_o             <= pct_q[0];
      pct50_o            <= pct_q[1];
      pct95_o            <= pct_q[2];
      pct99_o            <= pct_q[3];
      bucket_index_o     <= '0;
      bucket_tally_o     <= '0;
      last_o             <= 1'b1;
    end
    if (state_q == StHOut) begin
      hb_q               <= hb_q + 4'd1;
      result_kind_o      <= KindHist;
      sample_total_o     <= '0;
      mean_latency_o     <= '0;
      least_latency_o    <= '0;
      greatest_latency_o <= '0;
      pct5_o             <= '0;
      pct50_o            <= '0;
      pct95_o            <= '0;
      pct99_o            <= '0;
      bucket_index_o     <= hb_q;
      bucket_tally_o     <= 11'(32'(hist_q[hb_q]));
      last_o             <= hb_q == 4'(NumBuckets - 1);
    end
  end

  // The fill level never passes the window size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= win_q)
    else $error("window fill exceeds window size");

  // The write position stays inside the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FW+1)'(head_q) < (FW+1)'(win_q))
    else $error("ring head outside window");

  // A final beat is a stats beat or the unbounded bucket.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |->
      result_kind_o == KindStats || bucket_index_o == 4'(NumBuckets - 1))
    else $error("final beat on wrong result");

  // Histogram beats follow each other with rising bucket numbers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == KindHist && !last_o |=>
      result_valid_o && bucket_index_o == $past(bucket_index_o) + 4'd1)
    else $error("histogram beats out of sequence");

endmodule

`default_nettype wire

// ===== sv/lws_ram.sv =====
// ----------------------------------------------------------------------------
// lws_ram: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lws_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== sv/lws_div.sv =====
// ----------------------------------------------------------------------------
// lws_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a 64-bit divisor, one quotient
// bit per cycle; done pulses when the quotient is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lws_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quotient_o
);

  logic [63:0] rem_q, quo_q, dvs_q;
  logic [6:0]  cnt_q;
  logic        run_q;
  logic [64:0] rem_sh;
  logic        fits;

  // One restoring step.
  always_comb begin
    rem_sh = {rem_q, quo_q[63]};
    fits   = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire
